[src/tmps_pkg.sv]
package tmps_pkg;

	// triangle depth held in the row store
	localparam int MAX_ROWS   = 256;
	// significant bits of an entry, sign-extended from here
	localparam int VALUE_BITS = 16;

	localparam int VALUE_W    = 16;
	localparam int SUM_W      = 25;
	localparam int WIDE_W     = SUM_W + 1;
	localparam int ADDR_W     = $clog2(MAX_ROWS);
	localparam int ROW_W      = $clog2(MAX_ROWS + 1);
	localparam int OUT_DATA_W = ((SUM_W + 7) / 8) * 8;

	typedef logic signed [SUM_W-1:0] sum_t;

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

[src/triangle_min_path_sum.sv]
// channel  dir  tdata                          tuser        tlast
// s_axis   in   [15:0] value (signed)          -            last entry
// m_axis   out  [24:0] min_total (signed),     [0] overflow -
//               [31:25] zero
//
// one entry per cycle sustained, unless a last entry waits on a stalled result;
// a result follows the request marked last through the row store read at the
// accepting edge, the add and compare in stage 1, then the output register
// the row store read and write-back run in the same cycle; a read of the
// entry still being written takes the sum from the forwarding register
// arst_n clears counters, the too-deep flag and valids; the row store is not cleared
// a stalled result holds only the stage behind it, so the input keeps flowing
// until a second result is ready
module triangle_min_path_sum
	import tmps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [VALUE_W-1:0]    s_axis_tdata,   // [15:0] value
	input  logic                  s_axis_tlast,   // last entry of the triangle
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [24:0] min_total, rest zero
	output logic                  m_axis_tuser    // [0] overflow
);

	// row store: path sums of the latest row
	sum_t mem [MAX_ROWS];

	// position counters, advanced on request
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] col_q;
	logic              too_deep_q;

	// stage 1
	logic               valid_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               last_s1;
	logic               deep_s1;
	logic               apex_s1;
	logic               first_s1;
	logic               edge_s1;
	logic               fwd_s1;
	logic [ADDR_W-1:0]  addr_s1;
	sum_t               mem_rd_s1;

	// running state of the current row
	sum_t left_q;
	sum_t row_min_q;
	sum_t last_sum_q;

	// output register
	logic out_valid_q;
	sum_t out_min_q;
	logic out_ovf_q;

	logic accept;
	logic s1_fire;
	logic deep_next;
	logic row_edge;

	logic signed [VALUE_BITS-1:0] val_raw;
	logic signed [WIDE_W-1:0]     wide_sum;
	sum_t above;
	sum_t parent;
	sum_t sum;
	sum_t row_min_new;

	assign s1_fire       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_fire;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign deep_next = too_deep_q || (row_q >= ROW_W'(MAX_ROWS));
	assign row_edge  = (ROW_W'(col_q) == row_q);

	// counters and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			too_deep_q <= 1'b0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				row_q      <= '0;
				col_q      <= '0;
				too_deep_q <= 1'b0;
			end else begin
				too_deep_q <= deep_next;
				if (!deep_next) begin
					if (row_edge) begin
						row_q <= row_q + 1'b1;
						col_q <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			deep_s1  <= deep_next;
			apex_s1  <= (row_q == '0);
			first_s1 <= (col_q == '0);
			edge_s1  <= row_edge;
			addr_s1  <= col_q;
			// write-back of the entry being read lands this same cycle
			fwd_s1   <= valid_s1 && !deep_s1 && (addr_s1 == col_q);
		end
	end

	// row store: read on request, write back from stage 1
	always_ff @(posedge clk) begin
		if (accept) begin
			mem_rd_s1 <= mem[col_q];
		end
		if (s1_fire && !deep_s1) begin
			mem[addr_s1] <= sum;
		end
	end

	// stage 1 arithmetic
	assign val_raw = value_s1[VALUE_BITS-1:0];
	assign above   = fwd_s1 ? last_sum_q : mem_rd_s1;

	always_comb begin
		if (apex_s1) begin
			parent = '0;
		end else if (first_s1) begin
			parent = above;
		end else if (edge_s1) begin
			parent = left_q;
		end else begin
			parent = (left_q < above) ? left_q : above;
		end
	end

	assign wide_sum = WIDE_W'(val_raw) + WIDE_W'(parent);

	// saturate to the result range
	always_comb begin
		if (wide_sum[WIDE_W-1] != wide_sum[WIDE_W-2]) begin
			sum = wide_sum[WIDE_W-1] ? SUM_MIN : SUM_MAX;
		end else begin
			sum = wide_sum[SUM_W-1:0];
		end
	end

	assign row_min_new = (first_s1 || (sum < row_min_q)) ? sum : row_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			row_min_q  <= SUM_MAX;
			last_sum_q <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				left_q    <= '0;
				row_min_q <= SUM_MAX;
			end else if (!deep_s1) begin
				left_q    <= above;
				row_min_q <= row_min_new;
			end
			if (!deep_s1) begin
				last_sum_q <= sum;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			out_min_q <= deep_s1 ? sum_t'(0) : row_min_new;
			out_ovf_q <= deep_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-SUM_W){1'b0}}, out_min_q};
	assign m_axis_tuser  = out_ovf_q;

endmodule
